### src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define MQLB_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// condition must never be seen outside reset
`define MQLB_ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");

`endif

### src/mqlb_pkg.sv
// ----------------------------------------------------------------------------
// mqlb_pkg
// Types, codes and defaults shared by the linked multi-queue buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mqlb_pkg;

  // field widths fixed by the interface
  localparam int DATA_W  = 32;
  localparam int QNUM_W  = 4;

  // parameter defaults
  localparam int NUM_QUEUES_DEF  = 16;
  localparam int POOL_DEPTH_DEF  = 256;
  localparam int VALUE_WIDTH_DEF = 32;

  // operation codes
  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic                     action;
    logic [QNUM_W-1:0]        queue_number;
    logic signed [DATA_W-1:0] value_in;
  } in_item_t;

  typedef struct packed {
    status_e                  status;
    logic signed [DATA_W-1:0] value_out;
    logic                     queue_now_empty;
  } out_item_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_FETCH
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic rd_lookup;
    logic rd_fetch;
    logic commit_enq;
    logic commit_deq;
    logic out_load;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic act_deq;
    logic bad_queue;
    logic q_empty;
    logic pool_full;
    logic out_full;
  } stat_t;

endpackage

### src/mqlb_ram.sv
// ----------------------------------------------------------------------------
// mqlb_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mqlb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/mqlb_ctrl.sv
// ----------------------------------------------------------------------------
// mqlb_ctrl
// Sequencer for one queue operation: lookup, optional entry fetch, commit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mqlb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          out_stall,
  input  mqlb_pkg::stat_t st,
  output mqlb_pkg::cmd_t  cmd
);

  import mqlb_pkg::*;

  state_e state;
  state_e state_next;
  logic   can_out;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // output register free or being emptied this cycle
  assign can_out  = !st.out_full || !out_stall;
  assign in_stall = (state != S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          cmd.rd_lookup = 1'b1;
          state_next    = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (st.act_deq && !st.bad_queue && !st.q_empty) begin
          cmd.rd_fetch = 1'b1;
          state_next   = S_FETCH;
        end else if (can_out) begin
          cmd.commit_enq = !st.act_deq && !st.bad_queue && !st.pool_full;
          cmd.out_load   = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_FETCH: begin
        if (can_out) begin
          cmd.commit_deq = 1'b1;
          cmd.out_load   = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### src/mqlb_datapath.sv
// ----------------------------------------------------------------------------
// mqlb_datapath
// Pointer and entry memories, free list, empty flags and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mqlb_datapath #(
  parameter int NUM_QUEUES  = mqlb_pkg::NUM_QUEUES_DEF,
  parameter int POOL_DEPTH  = mqlb_pkg::POOL_DEPTH_DEF,
  parameter int VALUE_WIDTH = mqlb_pkg::VALUE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  mqlb_pkg::in_item_t  in_data,
  input  logic                out_stall,
  output logic                out_valid,
  output mqlb_pkg::out_item_t out_data,
  input  mqlb_pkg::cmd_t      cmd,
  output mqlb_pkg::stat_t     st
);

  import mqlb_pkg::*;

  localparam int QW = $clog2(NUM_QUEUES);
  localparam int PW = $clog2(POOL_DEPTH);
  localparam int CW = $clog2(POOL_DEPTH + 1);
  localparam logic [8:0]    NQ_LIMIT = 9'(NUM_QUEUES);
  localparam logic [CW-1:0] POOL_CNT = CW'(POOL_DEPTH);

  in_item_t               item;
  logic [NUM_QUEUES-1:0]  q_empty;
  logic [PW-1:0]          free_head;
  logic [CW-1:0]          never_used;
  logic [CW-1:0]          free_count;

  logic [8:0]             in_q_ext;
  logic [8:0]             item_q_ext;
  logic [QW-1:0]          in_q;
  logic [QW-1:0]          q_idx;
  logic                   bad_queue;
  logic                   cur_empty;
  logic                   from_fresh;
  logic [PW-1:0]          e_new;
  logic                   last_entry;

  logic [PW-1:0]          head_rd;
  logic [PW-1:0]          tail_rd;
  logic [PW-1:0]          link_rd;
  logic [VALUE_WIDTH-1:0] val_rd;
  logic [VALUE_WIDTH-1:0] val_store;
  logic [DATA_W-1:0]      val_ext;

  logic                   head_we;
  logic [PW-1:0]          head_wd;
  logic                   link_we;
  logic [PW-1:0]          link_wa;
  logic [PW-1:0]          link_wd;
  logic [PW-1:0]          link_ra;
  out_item_t              res;

  // queue index decode
  assign in_q_ext   = 9'(in_data.queue_number);
  assign item_q_ext = 9'(item.queue_number);
  assign in_q       = in_q_ext[QW-1:0];
  assign q_idx      = item_q_ext[QW-1:0];
  assign bad_queue  = (item_q_ext >= NQ_LIMIT);
  assign cur_empty  = q_empty[q_idx];

  // entry allocation: fresh entries first, then the free list
  assign from_fresh = (never_used < POOL_CNT);
  assign e_new      = from_fresh ? never_used[PW-1:0] : free_head;
  assign last_entry = (head_rd == tail_rd);

  // value width adaptation
  generate
    if (VALUE_WIDTH > DATA_W) begin : g_wide
      assign val_store = {{(VALUE_WIDTH - DATA_W){item.value_in[DATA_W-1]}}, item.value_in};
      assign val_ext   = val_rd[DATA_W-1:0];
    end else if (VALUE_WIDTH == DATA_W) begin : g_same
      assign val_store = item.value_in;
      assign val_ext   = val_rd;
    end else begin : g_narrow
      assign val_store = item.value_in[VALUE_WIDTH-1:0];
      assign val_ext   = {{(DATA_W - VALUE_WIDTH){val_rd[VALUE_WIDTH-1]}}, val_rd};
    end
  endgenerate

  // item register
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= in_data;
    end
  end

  // empty flags and free list bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      q_empty    <= '1;
      free_head  <= '0;
      never_used <= '0;
      free_count <= POOL_CNT;
    end else if (cmd.commit_enq) begin
      q_empty[q_idx] <= 1'b0;
      free_count     <= free_count - 1'b1;
      if (from_fresh) begin
        never_used <= never_used + 1'b1;
      end else begin
        free_head <= link_rd;
      end
    end else if (cmd.commit_deq) begin
      if (last_entry) begin
        q_empty[q_idx] <= 1'b1;
      end
      free_head  <= head_rd;
      free_count <= free_count + 1'b1;
    end
  end

  // memory port steering
  assign head_we = (cmd.commit_enq && cur_empty) || (cmd.commit_deq && !last_entry);
  assign head_wd = cmd.commit_deq ? link_rd : e_new;
  assign link_we = (cmd.commit_enq && !cur_empty) || cmd.commit_deq;
  assign link_wa = cmd.commit_deq ? head_rd : tail_rd;
  assign link_wd = cmd.commit_deq ? free_head : e_new;
  assign link_ra = cmd.rd_fetch ? head_rd : free_head;

  mqlb_ram #(.WIDTH(PW), .DEPTH(NUM_QUEUES)) u_head_ram (
    .clk     (clk),
    .wr_en   (head_we),
    .wr_addr (q_idx),
    .wr_data (head_wd),
    .rd_en   (cmd.rd_lookup),
    .rd_addr (in_q),
    .rd_data (head_rd)
  );

  mqlb_ram #(.WIDTH(PW), .DEPTH(NUM_QUEUES)) u_tail_ram (
    .clk     (clk),
    .wr_en   (cmd.commit_enq),
    .wr_addr (q_idx),
    .wr_data (e_new),
    .rd_en   (cmd.rd_lookup),
    .rd_addr (in_q),
    .rd_data (tail_rd)
  );

  mqlb_ram #(.WIDTH(PW), .DEPTH(POOL_DEPTH)) u_link_ram (
    .clk     (clk),
    .wr_en   (link_we),
    .wr_addr (link_wa),
    .wr_data (link_wd),
    .rd_en   (cmd.rd_lookup || cmd.rd_fetch),
    .rd_addr (link_ra),
    .rd_data (link_rd)
  );

  mqlb_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(POOL_DEPTH)) u_value_ram (
    .clk     (clk),
    .wr_en   (cmd.commit_enq),
    .wr_addr (e_new),
    .wr_data (val_store),
    .rd_en   (cmd.rd_fetch),
    .rd_addr (head_rd),
    .rd_data (val_rd)
  );

  // result selection
  always_comb begin
    res.status          = ST_DONE;
    res.value_out       = '0;
    res.queue_now_empty = 1'b0;
    if (bad_queue) begin
      res.status          = (item.action == ACT_DEQ) ? ST_EMPTY : ST_FULL;
      res.queue_now_empty = 1'b1;
    end else if (item.action == ACT_ENQ) begin
      if (st.pool_full) begin
        res.status          = ST_FULL;
        res.queue_now_empty = cur_empty;
      end
    end else if (cur_empty) begin
      res.status          = ST_EMPTY;
      res.queue_now_empty = 1'b1;
    end else begin
      res.value_out       = val_ext;
      res.queue_now_empty = last_entry;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= res;
    end
  end

  // status to controller
  assign st.act_deq   = (item.action == ACT_DEQ);
  assign st.bad_queue = bad_queue;
  assign st.q_empty   = cur_empty;
  assign st.pool_full = (free_count == '0);
  assign st.out_full  = out_valid;

endmodule

### src/multi_queue_linked_buffer_top.sv
// ----------------------------------------------------------------------------
// multi_queue_linked_buffer_top
// Several FIFO queues sharing one pool of linked entries.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid / in_stall / in_data) takes one operation per
//   transfer: enqueue value_in at the tail of queue_number, or dequeue its
//   head. out channel (out_valid / out_stall / out_data) returns exactly one
//   result per operation, in order: status, value_out, queue_now_empty.
//   An enqueue or a failed dequeue is answered after the lookup; a successful
//   dequeue also needs a fetch, as its entry address comes from the head
//   pointer read and must then be read from the entry memories. One
//   operation is in flight at a time, so an item is taken only after the last
//   one has loaded its result; each memory has one read and one write port.
//   Reset leaves all queues empty and the whole pool free; no clearing pass
//   is run and the block takes items right after reset.
//   While out_stall holds a result, the block still accepts the next item and
//   runs its lookup, then waits with in_stall high until the result register
//   is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_queue_linked_buffer_top #(
  parameter int NUM_QUEUES  = mqlb_pkg::NUM_QUEUES_DEF,
  parameter int POOL_DEPTH  = mqlb_pkg::POOL_DEPTH_DEF,
  parameter int VALUE_WIDTH = mqlb_pkg::VALUE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  mqlb_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mqlb_pkg::out_item_t out_data
);

  import mqlb_pkg::*;

  cmd_t  cmd;
  stat_t st;

  // operation sequencer
  mqlb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  // queue storage and result register
  mqlb_datapath #(
    .NUM_QUEUES  (NUM_QUEUES),
    .POOL_DEPTH  (POOL_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

### src/mqlb_checker.sv
// ----------------------------------------------------------------------------
// mqlb_checker
// Port-level checks for the linked multi-queue buffer, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mqlb_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input mqlb_pkg::out_item_t out_data
);

  import mqlb_pkg::*;

  // stalled result stays put
  `MQLB_ASSERT(a_out_hold, clk, rst, (out_valid && out_stall) |=> (out_valid && $stable(out_data)))

  // one operation in flight: busy right after a transfer
  `MQLB_ASSERT(a_busy_after_xfer, clk, rst, (in_valid && !in_stall) |=> in_stall)

  // only a successful operation carries a value
  `MQLB_ASSERT_NEVER(a_value_only_done, clk, rst,
    out_valid && (out_data.value_out != '0) && (out_data.status != ST_DONE))

  // an empty report always leaves the queue empty
  `MQLB_ASSERT(a_empty_flag, clk, rst,
    (out_valid && (out_data.status == ST_EMPTY)) |-> out_data.queue_now_empty)

endmodule

bind multi_queue_linked_buffer_top mqlb_checker u_mqlb_checker (.*);

### test/multi_queue_linked_buffer_top_tb.sv
// ----------------------------------------------------------------------------
// multi_queue_linked_buffer_top_tb
// Self-checking bench for the linked multi-queue buffer. A short table of
// directed operations runs first. Random fill and drain traffic follows,
// under several sender and receiver idling mixes. Results are checked
// against typed rows or a behavioral copy of queues, pointers, free list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_queue_linked_buffer_top_tb;
  import mqlb_pkg::*;

  localparam int QUEUES     = NUM_QUEUES_DEF;
  localparam int POOL       = POOL_DEPTH_DEF;
  localparam int PHASE_OPS  = 288;
  localparam int QUIET_MAX  = 2000;
  localparam int TAIL_WAIT  = 20;
  localparam int FULL_TURNS = 6;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  multi_queue_linked_buffer_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // shadow copy of the queue state
  logic [7:0]  head_q [QUEUES];
  logic [7:0]  tail_q [QUEUES];
  logic        q_empty [QUEUES];
  logic [31:0] pool_value [POOL];
  logic [7:0]  pool_link [POOL];
  logic [7:0]  free_top;
  logic [8:0]  fresh_next;
  logic [8:0]  free_cnt;

  out_item_t result_q [$];
  int        errors        = 0;
  int        send_idle_pct = 0;
  int        stall_pct     = 0;
  int        quiet         = 0;
  int        full_hits     = 0;
  bit        filling       = 1'b1;

  // directed table
  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } step_row_t;

  step_row_t plan [$];

  task automatic add_row(logic act, logic [3:0] q, logic [31:0] v, bit typed,
                         status_e st, logic [31:0] vo, logic ne);
    step_row_t r;
    r.item.action          = act;
    r.item.queue_number    = q;
    r.item.value_in        = v;
    r.typed                = typed;
    r.want.status          = st;
    r.want.value_out       = vo;
    r.want.queue_now_empty = ne;
    plan.push_back(r);
  endtask

  // queue state after reset
  task automatic clear_queues();
    for (int i = 0; i < QUEUES; i++) begin
      head_q[i]  = '0;
      tail_q[i]  = '0;
      q_empty[i] = 1'b1;
    end
    free_top   = '0;
    fresh_next = '0;
    free_cnt   = 9'(POOL);
  endtask

  // apply one operation to the shadow queues and return its result
  function automatic out_item_t queue_apply(in_item_t it);
    out_item_t  r;
    logic [7:0] e;
    int         q;
    r.status          = ST_DONE;
    r.value_out       = '0;
    r.queue_now_empty = 1'b1;
    q = it.queue_number;
    if (q >= QUEUES) begin
      r.status = (it.action == ACT_DEQ) ? ST_EMPTY : ST_FULL;
      return r;
    end
    if (it.action == ACT_ENQ) begin
      if (free_cnt == 0) begin
        r.status = ST_FULL;
      end else begin
        // untouched entries first, then the free list
        if (fresh_next < POOL) begin
          e = fresh_next[7:0];
          fresh_next++;
        end else begin
          e = free_top;
          free_top = pool_link[e];
        end
        free_cnt--;
        pool_value[e] = it.value_in;
        pool_link[e]  = '0;
        if (q_empty[q]) begin
          head_q[q]  = e;
          q_empty[q] = 1'b0;
        end else begin
          pool_link[tail_q[q]] = e;
        end
        tail_q[q] = e;
      end
    end else begin
      if (q_empty[q]) begin
        r.status = ST_EMPTY;
      end else begin
        e = head_q[q];
        r.value_out = pool_value[e];
        if (e == tail_q[q]) q_empty[q] = 1'b1;
        else head_q[q] = pool_link[e];
        pool_link[e] = free_top;
        free_top     = e;
        free_cnt++;
      end
    end
    r.queue_now_empty = q_empty[q];
    return r;
  endfunction

  // values weighted toward the extremes
  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // random operation: fill or drain bias, with some noise
  function automatic in_item_t pick_op();
    in_item_t it;
    int       start;
    int       idx;
    it.value_in     = pick_value();
    it.queue_number = 4'($urandom_range(QUEUES - 1));
    if ($urandom_range(9) == 0) begin
      it.action = 1'($urandom_range(1));
    end else if (filling) begin
      it.action = ($urandom_range(9) == 0) ? ACT_DEQ : ACT_ENQ;
    end else begin
      it.action = ($urandom_range(9) == 0) ? ACT_ENQ : ACT_DEQ;
      // mostly aim dequeues at a queue that holds something
      if (it.action == ACT_DEQ && $urandom_range(4) != 0) begin
        start = $urandom_range(QUEUES - 1);
        for (int k = 0; k < QUEUES; k++) begin
          idx = (start + k) % QUEUES;
          if (!q_empty[idx]) begin
            it.queue_number = 4'(idx);
            break;
          end
        end
      end
    end
    return it;
  endfunction

  // one input transfer, with a random lead-in gap
  task automatic transfer_op(in_item_t it, bit typed, out_item_t want);
    out_item_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = queue_apply(it);
    if (pred.status == ST_FULL) full_hits++;
    result_q.push_back(typed ? want : pred);
  endtask

  // hold the sender until every result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
  endtask

  // result checking and receiver stalls
  out_item_t want_res;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $display("%0t: result with nothing expected, actual %p", $time, out_data);
          errors++;
        end else begin
          want_res = result_q.pop_front();
          if (out_data.status !== want_res.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     want_res.status, out_data.status);
            errors++;
          end
          if (out_data.value_out !== want_res.value_out) begin
            $display("%0t: value_out expected %h actual %h", $time,
                     want_res.value_out, out_data.value_out);
            errors++;
          end
          if (out_data.queue_now_empty !== want_res.queue_now_empty) begin
            $display("%0t: queue_now_empty expected %b actual %b", $time,
                     want_res.queue_now_empty, out_data.queue_now_empty);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_MAX) begin
        $display("%0t: no transfer for %0d cycles", $time, QUIET_MAX);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    in_item_t rnd_op;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    clear_queues();

    // empty queues, extreme values, ordering, queue interleave
    add_row(ACT_DEQ, 4'd0,  32'h1234_5678, 1, ST_EMPTY, 32'h0, 1'b1);
    add_row(ACT_DEQ, 4'd15, 32'hffff_ffff, 1, ST_EMPTY, 32'h0, 1'b1);
    add_row(ACT_ENQ, 4'd0,  32'h7fff_ffff, 1, ST_DONE,  32'h0, 1'b0);
    add_row(ACT_ENQ, 4'd0,  32'h8000_0000, 1, ST_DONE,  32'h0, 1'b0);
    add_row(ACT_ENQ, 4'd15, 32'hffff_ffff, 1, ST_DONE,  32'h0, 1'b0);
    add_row(ACT_ENQ, 4'd15, 32'h0000_0000, 1, ST_DONE,  32'h0, 1'b0);
    add_row(ACT_DEQ, 4'd0,  32'h0000_0000, 1, ST_DONE,  32'h7fff_ffff, 1'b0);
    add_row(ACT_DEQ, 4'd0,  32'hffff_ffff, 1, ST_DONE,  32'h8000_0000, 1'b1);
    add_row(ACT_DEQ, 4'd0,  32'h0000_0000, 1, ST_EMPTY, 32'h0, 1'b1);
    add_row(ACT_DEQ, 4'd15, 32'h0000_0000, 0, ST_DONE,  32'h0, 1'b0);
    add_row(ACT_DEQ, 4'd15, 32'h0000_0000, 0, ST_DONE,  32'h0, 1'b0);
    add_row(ACT_ENQ, 4'd7,  32'h5555_5555, 0, ST_DONE,  32'h0, 1'b0);
    add_row(ACT_ENQ, 4'd8,  32'haaaa_aaaa, 0, ST_DONE,  32'h0, 1'b0);
    add_row(ACT_ENQ, 4'd7,  32'h0000_0001, 0, ST_DONE,  32'h0, 1'b0);
    add_row(ACT_DEQ, 4'd8,  32'h0000_0000, 0, ST_DONE,  32'h0, 1'b0);
    add_row(ACT_DEQ, 4'd7,  32'h0000_0000, 0, ST_DONE,  32'h0, 1'b0);
    add_row(ACT_ENQ, 4'd7,  32'hfeed_0042, 0, ST_DONE,  32'h0, 1'b0);
    add_row(ACT_DEQ, 4'd7,  32'h0000_0000, 0, ST_DONE,  32'h0, 1'b0);
    add_row(ACT_DEQ, 4'd7,  32'h0000_0000, 0, ST_DONE,  32'h0, 1'b0);
    add_row(ACT_DEQ, 4'd7,  32'h0000_0000, 0, ST_DONE,  32'h0, 1'b0);
    add_row(ACT_DEQ, 4'd8,  32'h0000_0000, 1, ST_EMPTY, 32'h0, 1'b1);

    foreach (plan[i]) transfer_op(plan[i].item, plan[i].typed, plan[i].want);
    drain_results();

    // random fill and drain under each idling mix
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 70; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 70; end
        default: begin send_idle_pct = 26; stall_pct = 26; end
      endcase
      for (int n = 0; n < PHASE_OPS; n++) begin
        rnd_op = pick_op();
        transfer_op(rnd_op, 1'b0, '0);
        // turn around once the pool has overflowed or fully emptied
        if (filling && full_hits >= FULL_TURNS) begin
          filling   = 1'b0;
          full_hits = 0;
        end else if (!filling && free_cnt == POOL) begin
          filling = 1'b1;
        end
      end
      drain_results();
    end

    repeat (TAIL_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
